// ===== sv/assert_macros.svh =====
// Assertion helpers used by the file that checks the block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold in the same cycle as its trigger.
`define GSLI_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Property that must hold in the cycle after its trigger.
`define GSLI_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/gsli_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsli_pkg
// Shared constants, operation codes and control types of the grid search
// interpolator.
// ----------------------------------------------------------------------------
package gsli_pkg;

	localparam int GRID_DEPTH_DEF  = 1024;
	localparam int VALUE_BITS_DEF  = 32;
	localparam int POLICY_BITS_DEF = 8;
	localparam int MODE_W          = 3;
	localparam int PTS_RESET       = 2;

	localparam logic [MODE_W-1:0] MODE_WR_GRID   = 3'd0;
	localparam logic [MODE_W-1:0] MODE_WR_FUNC   = 3'd1;
	localparam logic [MODE_W-1:0] MODE_WR_POLICY = 3'd2;
	localparam logic [MODE_W-1:0] MODE_INTERP    = 3'd3;
	localparam logic [MODE_W-1:0] MODE_CHOICE    = 3'd4;

	typedef enum logic [3:0] {
		OP_IDLE, OP_RD_LOW, OP_RD_HIGH, OP_CHK_HIGH, OP_SRCH_RD, OP_SRCH_CMP,
		OP_FETCH0, OP_FETCH1, OP_FETCH2, OP_MUL_LO, OP_MUL_HI, OP_DIV_INIT,
		OP_DIV_STEP, OP_FINISH
	} dp_op_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_RD_LOW, ST_RD_HIGH, ST_CHK_HIGH, ST_SRCH_RD, ST_SRCH_CMP,
		ST_FETCH0, ST_FETCH1, ST_FETCH2, ST_MUL_LO, ST_MUL_HI, ST_DIV_INIT,
		ST_DIV_STEP, ST_FINISH
	} ctl_state_t;

	typedef struct packed {
		dp_op_t op;
		logic   accept;
		logic   out_load;
	} cmd_t;

	typedef struct packed {
		logic below;
		logic at_high;
		logic more_init;
		logic more;
		logic choice;
		logic degenerate;
	} sts_t;

endpackage

// ===== sv/grid_search_linear_interpolation.sv =====
// A table write is finished in the beat that carries it. A choice lookup
// bisects the grid table and then fetches the policy entry; an interpolation
// bisects the grid table, fetches the segment ends, multiplies and then runs
// the one-bit-a-cycle divider. One query is in flight at a time; a finished
// result waits in the output register while the next beat is taken.
// Reset clears control state and the point count only.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_search_linear_interpolation
// Piecewise linear interpolation and policy lookup over a loaded grid.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module grid_search_linear_interpolation #(
	parameter int GRID_DEPTH  = gsli_pkg::GRID_DEPTH_DEF,
	parameter int VALUE_BITS  = gsli_pkg::VALUE_BITS_DEF,
	parameter int POLICY_BITS = gsli_pkg::POLICY_BITS_DEF,
	localparam int IDX_W      = $clog2(GRID_DEPTH),
	localparam int CNT_W      = IDX_W + 1,
	localparam int TD_W       = ((IDX_W + VALUE_BITS + 7) / 8) * 8
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [TD_W-1:0]             s_tdata,  // entry_index, operand_value
	input  logic [gsli_pkg::MODE_W-1:0] s_tuser,  // mode
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [TD_W-1:0]             m_tdata,  // result_value, segment_index
	output logic [0:0]                  m_tuser,  // degenerate_segment
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [CNT_W-1:0]            cfg_data  // points_in_use
);

	gsli_pkg::cmd_t              cmd;
	gsli_pkg::sts_t              sts;
	logic signed [VALUE_BITS-1:0] out_value;
	logic [IDX_W-1:0]             out_segment;
	logic                         out_degenerate;
	logic                         s_beat, s_write, s_query;

	assign cfg_ready = 1'b1;

	gsli_ctrl #(.VALUE_BITS(VALUE_BITS)) u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_tvalid), .in_ready(s_tready), .in_mode(s_tuser),
		.out_valid(m_tvalid), .out_ready(m_tready),
		.cmd(cmd), .sts(sts)
	);

	gsli_dpath #(
		.GRID_DEPTH(GRID_DEPTH), .VALUE_BITS(VALUE_BITS), .POLICY_BITS(POLICY_BITS)
	) u_dpath (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.in_mode(s_tuser),
		.in_index(s_tdata[IDX_W-1:0]),
		.in_value(s_tdata[IDX_W+VALUE_BITS-1:IDX_W]),
		.cfg_we(cfg_valid && cfg_ready), .cfg_wdata(cfg_data),
		.out_value(out_value), .out_segment(out_segment),
		.out_degenerate(out_degenerate)
	);

	assign m_tdata = TD_W'({out_segment, out_value});
	assign m_tuser = out_degenerate;

	assign s_beat  = s_tvalid && s_tready;
	assign s_write = s_tuser inside {gsli_pkg::MODE_WR_GRID, gsli_pkg::MODE_WR_FUNC,
		gsli_pkg::MODE_WR_POLICY};
	assign s_query = s_tuser inside {gsli_pkg::MODE_INTERP, gsli_pkg::MODE_CHOICE};

	// A table write is finished in the beat that carries it.
	`GSLI_ASSERT_NEXT(a_write_one_beat, s_beat && s_write, s_tready, "write beat stalled the input")
	`GSLI_ASSERT_NEXT(a_query_busy, s_beat && s_query, !s_tready, "input taken while a query runs")
	`GSLI_ASSERT_NOW(a_degenerate_zero, m_tvalid && m_tuser[0], m_tdata[VALUE_BITS-1:0] == '0, "degenerate segment with non-zero value")

endmodule

// ===== sv/gsli_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsli_ram
// Single write port, single read port table with registered read data.
// ----------------------------------------------------------------------------
module gsli_ram #(
	parameter int DEPTH = gsli_pkg::GRID_DEPTH_DEF,
	parameter int WIDTH = gsli_pkg::VALUE_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== sv/gsli_dpath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsli_dpath
// Tables, search registers, shift-add multiplier, restoring divider and the
// result register of the grid search interpolator.
// ----------------------------------------------------------------------------
module gsli_dpath #(
	parameter int GRID_DEPTH  = gsli_pkg::GRID_DEPTH_DEF,
	parameter int VALUE_BITS  = gsli_pkg::VALUE_BITS_DEF,
	parameter int POLICY_BITS = gsli_pkg::POLICY_BITS_DEF,
	localparam int IDX_W      = $clog2(GRID_DEPTH),
	localparam int CNT_W      = IDX_W + 1
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  gsli_pkg::cmd_t                 cmd,
	output gsli_pkg::sts_t                 sts,
	input  logic [gsli_pkg::MODE_W-1:0]    in_mode,
	input  logic [IDX_W-1:0]               in_index,
	input  logic signed [VALUE_BITS-1:0]   in_value,
	input  logic                           cfg_we,
	input  logic [CNT_W-1:0]               cfg_wdata,
	output logic signed [VALUE_BITS-1:0]   out_value,
	output logic [IDX_W-1:0]               out_segment,
	output logic                           out_degenerate
);

	localparam int VB = VALUE_BITS;
	localparam int H  = (VB + 1) / 2;
	localparam int HB = VB - H;

	logic [CNT_W-1:0]             pts_q, n_eff, nm1, nm2;
	logic [gsli_pkg::MODE_W-1:0]  mode_q;
	logic signed [VB-1:0]         x_q, g0_q, f0_q;
	logic [IDX_W-1:0]             lo_q, hi_q, seg_q, hi0, mid, segc, seg1, nlo, nhi;
	logic [IDX_W:0]               mid_sum;
	logic [POLICY_BITS-1:0]       pol_q;
	logic [VB-1:0]                dm_q, sm_q, tm_q;
	logic                         neg_q, deg_q, over_q;
	logic [2*VB-1:0]              prod_q;
	logic [VB-1:0]                rem_q;
	logic [VB:0]                  dv_q;
	logic                         is_choice, in_range, gt;
	logic [IDX_W-1:0]             ga, fa;
	logic signed [VB-1:0]         gq, fq;
	logic [POLICY_BITS-1:0]       pq;
	logic signed [VB:0]           dd, tt, ss, dabs, tabs, sabs;
	logic [H-1:0]                 mul_b;
	logic [VB+H-1:0]              mul_p;
	logic [VB:0]                  trial;
	logic                         ge;
	logic [VB:0]                  diff;
	logic                         qneg;
	logic signed [VB+2:0]         sum;
	logic signed [VB-1:0]         arith;
	logic                         wr_g, wr_f, wr_p;

	localparam logic signed [VB-1:0] VMAX = {1'b0, {(VB-1){1'b1}}};
	localparam logic signed [VB-1:0] VMIN = {1'b1, {(VB-1){1'b0}}};

	assign in_range = {1'b0, in_index} < CNT_W'(GRID_DEPTH);
	assign wr_g = cmd.accept && in_range && (in_mode == gsli_pkg::MODE_WR_GRID);
	assign wr_f = cmd.accept && in_range && (in_mode == gsli_pkg::MODE_WR_FUNC);
	assign wr_p = cmd.accept && in_range && (in_mode == gsli_pkg::MODE_WR_POLICY);

	gsli_ram #(.DEPTH(GRID_DEPTH), .WIDTH(VB)) u_grid (
		.clk(clk), .we(wr_g), .waddr(in_index), .wdata(in_value), .raddr(ga), .rdata(gq)
	);
	gsli_ram #(.DEPTH(GRID_DEPTH), .WIDTH(VB)) u_func (
		.clk(clk), .we(wr_f), .waddr(in_index), .wdata(in_value), .raddr(fa), .rdata(fq)
	);
	gsli_ram #(.DEPTH(GRID_DEPTH), .WIDTH(POLICY_BITS)) u_pol (
		.clk(clk), .we(wr_p), .waddr(in_index), .wdata(in_value[POLICY_BITS-1:0]),
		.raddr(segc), .rdata(pq)
	);

	// Effective point count, clamped to the usable range.
	always_comb begin
		if (pts_q < CNT_W'(2)) begin
			n_eff = CNT_W'(2);
		end else if (pts_q > CNT_W'(GRID_DEPTH)) begin
			n_eff = CNT_W'(GRID_DEPTH);
		end else begin
			n_eff = pts_q;
		end
	end

	assign nm1       = n_eff - CNT_W'(1);
	assign nm2       = n_eff - CNT_W'(2);
	assign is_choice = (mode_q == gsli_pkg::MODE_CHOICE);
	assign hi0       = is_choice ? nm1[IDX_W-1:0] : nm2[IDX_W-1:0];
	assign mid_sum   = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid       = mid_sum[IDX_W:1];
	assign gt        = gq > x_q;
	assign nlo       = gt ? lo_q : mid;
	assign nhi       = gt ? mid : hi_q;
	assign segc      = (!is_choice && ({1'b0, seg_q} > nm2)) ? nm2[IDX_W-1:0] : seg_q;
	assign seg1      = seg_q + IDX_W'(1);

	assign sts.below      = x_q < gq;
	assign sts.at_high    = x_q >= gq;
	assign sts.more_init  = {1'b0, hi0} > (IDX_W+1)'(2);
	assign sts.more       = {1'b0, nhi} > ({1'b0, nlo} + (IDX_W+1)'(1));
	assign sts.choice     = is_choice;
	assign sts.degenerate = (gq == g0_q);

	always_comb begin
		case (cmd.op)
			gsli_pkg::OP_RD_LOW:  ga = IDX_W'(1);
			gsli_pkg::OP_RD_HIGH: ga = hi0;
			gsli_pkg::OP_SRCH_RD: ga = mid;
			gsli_pkg::OP_FETCH0:  ga = segc;
			gsli_pkg::OP_FETCH1:  ga = seg1;
			default:              ga = seg_q;
		endcase
	end
	assign fa = (cmd.op == gsli_pkg::OP_FETCH1) ? seg1 : segc;

	assign dd   = {gq[VB-1], gq} - {g0_q[VB-1], g0_q};
	assign tt   = {x_q[VB-1], x_q} - {g0_q[VB-1], g0_q};
	assign ss   = {fq[VB-1], fq} - {f0_q[VB-1], f0_q};
	assign dabs = dd[VB] ? -dd : dd;
	assign tabs = tt[VB] ? -tt : tt;
	assign sabs = ss[VB] ? -ss : ss;

	// One multiplier, used for the low and then the high half of |t|.
	assign mul_b = (cmd.op == gsli_pkg::OP_MUL_HI) ? H'(tm_q[VB-1:H]) : tm_q[H-1:0];
	assign mul_p = sm_q * mul_b;

	assign trial = {rem_q, dv_q[VB]};
	assign ge    = trial >= {1'b0, dm_q};
	assign diff  = trial - {1'b0, dm_q};

	assign qneg = neg_q && (|dv_q);
	assign sum  = qneg ? ({{3{f0_q[VB-1]}}, f0_q} - {2'b00, dv_q})
	                   : ({{3{f0_q[VB-1]}}, f0_q} + {2'b00, dv_q});

	always_comb begin
		if (over_q) begin
			arith = qneg ? VMIN : VMAX;
		end else if ((&sum[VB+2:VB-1]) || !(|sum[VB+2:VB-1])) begin
			arith = sum[VB-1:0];
		end else begin
			arith = sum[VB+2] ? VMIN : VMAX;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pts_q <= CNT_W'(gsli_pkg::PTS_RESET);
		end else if (cfg_we) begin
			pts_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			gsli_pkg::OP_IDLE: begin
				if (cmd.accept) begin
					mode_q <= in_mode;
					x_q    <= in_value;
				end
			end
			gsli_pkg::OP_RD_HIGH: begin
				seg_q <= '0;
			end
			gsli_pkg::OP_CHK_HIGH: begin
				lo_q  <= IDX_W'(1);
				hi_q  <= hi0;
				seg_q <= sts.at_high ? hi0 : IDX_W'(1);
			end
			gsli_pkg::OP_SRCH_CMP: begin
				lo_q  <= nlo;
				hi_q  <= nhi;
				seg_q <= nlo;
			end
			gsli_pkg::OP_FETCH0: begin
				seg_q <= segc;
			end
			gsli_pkg::OP_FETCH1: begin
				g0_q  <= gq;
				f0_q  <= fq;
				pol_q <= pq;
			end
			gsli_pkg::OP_FETCH2: begin
				deg_q <= sts.degenerate;
				dm_q  <= dabs[VB-1:0];
				tm_q  <= tabs[VB-1:0];
				sm_q  <= sabs[VB-1:0];
				neg_q <= ss[VB] ^ tt[VB] ^ dd[VB];
			end
			gsli_pkg::OP_MUL_LO: begin
				prod_q <= (2*VB)'(mul_p);
			end
			gsli_pkg::OP_MUL_HI: begin
				prod_q <= prod_q + ({{HB{1'b0}}, mul_p} << H);
			end
			gsli_pkg::OP_DIV_INIT: begin
				// A high part at or above the divisor means the quotient overflows.
				over_q <= {1'b0, prod_q[2*VB-1:VB+1]} >= dm_q;
				rem_q  <= {1'b0, prod_q[2*VB-1:VB+1]};
				dv_q   <= prod_q[VB:0];
			end
			gsli_pkg::OP_DIV_STEP: begin
				rem_q <= ge ? diff[VB-1:0] : trial[VB-1:0];
				dv_q  <= {dv_q[VB-1:0], ge};
			end
			gsli_pkg::OP_FINISH: begin
				if (cmd.out_load) begin
					out_segment    <= seg_q;
					out_degenerate <= !is_choice && deg_q;
					if (is_choice) begin
						out_value <= VB'(pol_q);
					end else if (deg_q) begin
						out_value <= '0;
					end else begin
						out_value <= arith;
					end
				end
			end
			default: begin
			end
		endcase
	end

endmodule

// ===== sv/gsli_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsli_ctrl
// Sequencer of the grid search interpolator: search, fetch, multiply,
// divide and hand-off to the output register.
// ----------------------------------------------------------------------------
module gsli_ctrl #(
	parameter int VALUE_BITS = gsli_pkg::VALUE_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [gsli_pkg::MODE_W-1:0] in_mode,
	output logic                        out_valid,
	input  logic                        out_ready,
	output gsli_pkg::cmd_t              cmd,
	input  gsli_pkg::sts_t              sts
);

	localparam int DIV_CW = $clog2(VALUE_BITS + 1);

	gsli_pkg::ctl_state_t state_q, state_d;
	logic [DIV_CW-1:0]    cnt_q;
	logic                 ov_q;
	logic                 accept, is_query, out_load;

	assign in_ready = (state_q == gsli_pkg::ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign is_query = (in_mode == gsli_pkg::MODE_INTERP) || (in_mode == gsli_pkg::MODE_CHOICE);
	assign out_load = (state_q == gsli_pkg::ST_FINISH) && (!ov_q || out_ready);
	assign out_valid = ov_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			gsli_pkg::ST_IDLE:     if (accept && is_query) state_d = gsli_pkg::ST_RD_LOW;
			gsli_pkg::ST_RD_LOW:   state_d = gsli_pkg::ST_RD_HIGH;
			gsli_pkg::ST_RD_HIGH:  state_d = sts.below ? gsli_pkg::ST_FETCH0 : gsli_pkg::ST_CHK_HIGH;
			gsli_pkg::ST_CHK_HIGH: begin
				if (sts.at_high || !sts.more_init) state_d = gsli_pkg::ST_FETCH0;
				else state_d = gsli_pkg::ST_SRCH_RD;
			end
			gsli_pkg::ST_SRCH_RD:  state_d = gsli_pkg::ST_SRCH_CMP;
			gsli_pkg::ST_SRCH_CMP: state_d = sts.more ? gsli_pkg::ST_SRCH_RD : gsli_pkg::ST_FETCH0;
			gsli_pkg::ST_FETCH0:   state_d = gsli_pkg::ST_FETCH1;
			gsli_pkg::ST_FETCH1:   state_d = sts.choice ? gsli_pkg::ST_FINISH : gsli_pkg::ST_FETCH2;
			gsli_pkg::ST_FETCH2:   state_d = sts.degenerate ? gsli_pkg::ST_FINISH : gsli_pkg::ST_MUL_LO;
			gsli_pkg::ST_MUL_LO:   state_d = gsli_pkg::ST_MUL_HI;
			gsli_pkg::ST_MUL_HI:   state_d = gsli_pkg::ST_DIV_INIT;
			gsli_pkg::ST_DIV_INIT: state_d = gsli_pkg::ST_DIV_STEP;
			gsli_pkg::ST_DIV_STEP: if (cnt_q == DIV_CW'(VALUE_BITS)) state_d = gsli_pkg::ST_FINISH;
			gsli_pkg::ST_FINISH:   if (out_load) state_d = gsli_pkg::ST_IDLE;
			default:               state_d = gsli_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd.accept   = accept;
		cmd.out_load = out_load;
		case (state_q)
			gsli_pkg::ST_IDLE:     cmd.op = gsli_pkg::OP_IDLE;
			gsli_pkg::ST_RD_LOW:   cmd.op = gsli_pkg::OP_RD_LOW;
			gsli_pkg::ST_RD_HIGH:  cmd.op = gsli_pkg::OP_RD_HIGH;
			gsli_pkg::ST_CHK_HIGH: cmd.op = gsli_pkg::OP_CHK_HIGH;
			gsli_pkg::ST_SRCH_RD:  cmd.op = gsli_pkg::OP_SRCH_RD;
			gsli_pkg::ST_SRCH_CMP: cmd.op = gsli_pkg::OP_SRCH_CMP;
			gsli_pkg::ST_FETCH0:   cmd.op = gsli_pkg::OP_FETCH0;
			gsli_pkg::ST_FETCH1:   cmd.op = gsli_pkg::OP_FETCH1;
			gsli_pkg::ST_FETCH2:   cmd.op = gsli_pkg::OP_FETCH2;
			gsli_pkg::ST_MUL_LO:   cmd.op = gsli_pkg::OP_MUL_LO;
			gsli_pkg::ST_MUL_HI:   cmd.op = gsli_pkg::OP_MUL_HI;
			gsli_pkg::ST_DIV_INIT: cmd.op = gsli_pkg::OP_DIV_INIT;
			gsli_pkg::ST_DIV_STEP: cmd.op = gsli_pkg::OP_DIV_STEP;
			gsli_pkg::ST_FINISH:   cmd.op = gsli_pkg::OP_FINISH;
			default:               cmd.op = gsli_pkg::OP_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gsli_pkg::ST_IDLE;
			cnt_q   <= '0;
			ov_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == gsli_pkg::ST_DIV_INIT) begin
				cnt_q <= '0;
			end else if (state_q == gsli_pkg::ST_DIV_STEP) begin
				cnt_q <= cnt_q + DIV_CW'(1);
			end
			if (out_load) begin
				ov_q <= 1'b1;
			end else if (out_ready) begin
				ov_q <= 1'b0;
			end
		end
	end

endmodule
